// ===== rtl/aesb_pkg.sv =====
// AES block encryption: shared types, constants and round functions.
// Holds the S-box table, the key-store write request type and byte helpers.
// Used by aesb_key_ram, aesb_round and aes_block_encrypt.
`default_nettype none

package aesb_pkg;

	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned SLOT_IN_W = 4;
	localparam int unsigned RC_W = 4;
	localparam logic [RC_W-1:0] RC_RESET = 4'd10;
	localparam logic [7:0] GF_POLY = 8'h1b;

	localparam logic REQ_KEY_LOAD = 1'b0;
	localparam logic REQ_ENCRYPT  = 1'b1;

	typedef logic [BLOCK_W-1:0] block_t;

	typedef struct packed {
		logic                 en;
		logic [SLOT_IN_W-1:0] slot;
		block_t               data;
	} key_wr_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
		get_byte = b[BLOCK_W-1-8*i -: 8];
	endfunction

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	// SubBytes then ShiftRows
	function automatic block_t sub_shift(input block_t s);
		block_t t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
			end
		end
		sub_shift = t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, x;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			x  = a0 ^ a1 ^ a2 ^ a3;
			t[BLOCK_W-1-8*(4*c)   -: 8] = gf_dbl(a0 ^ a1) ^ a0 ^ x;
			t[BLOCK_W-1-8*(4*c+1) -: 8] = gf_dbl(a1 ^ a2) ^ a1 ^ x;
			t[BLOCK_W-1-8*(4*c+2) -: 8] = gf_dbl(a2 ^ a3) ^ a2 ^ x;
			t[BLOCK_W-1-8*(4*c+3) -: 8] = gf_dbl(a3 ^ a0) ^ a3 ^ x;
		end
		mix_columns = t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/aesb_key_ram.sv =====
// Round-key store: one synchronous memory, one write port, one read port.
// Read data is registered. Depends on aesb_pkg.
`default_nettype none

module aesb_key_ram #(
	parameter int unsigned KEY_SLOTS = 15,
	parameter int unsigned SLOT_W    = 4
) (
	input  wire logic             clk,
	input  wire aesb_pkg::key_wr_t key_wr,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output aesb_pkg::block_t      rd_data
);
	import aesb_pkg::*;

	block_t mem [KEY_SLOTS];
	block_t rd_data_q;

	always_ff @(posedge clk) begin
		if (key_wr.en) begin
			mem[key_wr.slot[SLOT_W-1:0]] <= key_wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/aesb_round.sv =====
// Shared AES round unit: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// The final round skips MixColumns. Depends on aesb_pkg.
`default_nettype none

module aesb_round (
	input  wire aesb_pkg::block_t state,
	input  wire aesb_pkg::block_t round_key,
	input  wire logic             last,
	output aesb_pkg::block_t      result
);
	import aesb_pkg::*;

	block_t shifted;
	block_t mixed;

	always_comb begin
		shifted = sub_shift(state);
		mixed   = mix_columns(shifted);
		result  = (last ? shifted : mixed) ^ round_key;
	end

endmodule

`default_nettype wire

// ===== rtl/aes_block_encrypt.sv =====
// AES block encryption top level: request decode, round sequencer, result register.
// Instantiates aesb_key_ram and aesb_round; depends on aesb_pkg.
//
// Channel  Direction  Handshake            Payload
// in       request    in_valid / in_ready  req_type, key_slot, block_hi, block_lo
// out      result     out_valid/out_ready  cipher_hi, cipher_lo
// cfg      write      cfg_we               cfg_wdata (round_count)
//
// An encrypt holds off the input through the key-add state and n rounds, n being the
// clamped round count (1 to 14 with the default KEY_SLOTS): one round per cycle through the
// shared round unit unless the final round stalls, each key read ahead from the key memory.
// Reset clears control and sets round_count to 10; the key memory is not cleared.
// A full result register stalls the final round until out_ready frees it.
`default_nettype none

module aes_block_encrypt #(
	parameter int unsigned KEY_SLOTS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [3:0]  key_slot,
	input  wire logic [63:0] block_hi,
	input  wire logic [63:0] block_lo,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      cipher_hi,
	output logic [63:0]      cipher_lo
);
	import aesb_pkg::*;

	localparam int unsigned SLOT_W = $clog2(KEY_SLOTS);
	localparam logic [RC_W-1:0] MAX_ROUND = RC_W'(KEY_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_LOAD  = 3'b010,
		ST_ROUND = 3'b100
	} seq_state_t;

	seq_state_t        st_q;
	logic [RC_W-1:0]   round_count_q;
	logic [SLOT_W-1:0] n_q;
	logic [SLOT_W-1:0] r_q;
	logic              out_valid_q;
	block_t            state_q;
	block_t            cipher_q;

	key_wr_t           key_wr;
	logic [SLOT_W-1:0] rd_addr;
	block_t            round_key;
	block_t            round_out;
	logic              accept;
	logic              enc_accept;
	logic              last;
	logic              out_free;
	logic              finish;
	logic [RC_W-1:0]   n_clamped;

	assign in_ready   = (st_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign enc_accept = accept && (req_type == REQ_ENCRYPT);
	assign last       = (r_q == n_q);
	assign out_free   = !out_valid_q || out_ready;
	assign finish     = (st_q == ST_ROUND) && last && out_free;

	always_comb begin
		key_wr.en   = accept && (req_type == REQ_KEY_LOAD)
			&& ({1'b0, key_slot} < 5'(KEY_SLOTS));
		key_wr.slot = key_slot;
		key_wr.data = {block_hi, block_lo};
	end

	always_comb begin
		if (round_count_q == '0) begin
			n_clamped = RC_W'(1);
		end else if (round_count_q > MAX_ROUND) begin
			n_clamped = MAX_ROUND;
		end else begin
			n_clamped = round_count_q;
		end
	end

	always_comb begin
		case (st_q)
			ST_IDLE:  rd_addr = '0;
			ST_LOAD:  rd_addr = SLOT_W'(1);
			ST_ROUND: rd_addr = last ? r_q : SLOT_W'(r_q + 1'b1);
			default:  rd_addr = '0;
		endcase
	end

	aesb_key_ram #(
		.KEY_SLOTS (KEY_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_key_ram (
		.clk     (clk),
		.key_wr  (key_wr),
		.rd_addr (rd_addr),
		.rd_data (round_key)
	);

	aesb_round u_round (
		.state     (state_q),
		.round_key (round_key),
		.last      (last),
		.result    (round_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			round_count_q <= RC_RESET;
			n_q           <= '0;
			r_q           <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				round_count_q <= cfg_wdata;
			end
			case (st_q)
				ST_IDLE: begin
					if (enc_accept) begin
						n_q  <= n_clamped[SLOT_W-1:0];
						st_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					r_q  <= SLOT_W'(1);
					st_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (!last) begin
						r_q <= SLOT_W'(r_q + 1'b1);
					end else if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc_accept) begin
			state_q <= {block_hi, block_lo};
		end else if (st_q == ST_LOAD) begin
			state_q <= state_q ^ round_key;
		end else if (st_q == ST_ROUND && !last) begin
			state_q <= round_out;
		end
		if (finish) begin
			cipher_q <= round_out;
		end
	end

	assign out_valid = out_valid_q;
	assign cipher_hi = cipher_q[BLOCK_W-1 -: HALF_W];
	assign cipher_lo = cipher_q[HALF_W-1:0];

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND) |-> (r_q <= n_q) && (n_q != '0))
		else $error("round index past round count");

	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid && (st_q == ST_IDLE))
		else $error("final round did not load result register");

	a_encrypt_starts: assert property (@(posedge clk) disable iff (!arst_n)
		enc_accept |=> (st_q == ST_LOAD) && !in_ready)
		else $error("encrypt request did not start sequencer");

	a_no_key_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr.en |-> (st_q == ST_IDLE) && !enc_accept)
		else $error("key write while encrypt in flight");

endmodule

`default_nettype wire

// ===== tb/aes_block_encrypt_test.sv =====
`timescale 1ns / 1ps
// Testbench for aes_block_encrypt: directed requests, then random phases with checking.
// Predicts each ciphertext with its own AES round model; depends on aesb_pkg and the RTL.

module aes_block_encrypt_test;
	import aesb_pkg::*;

	localparam int KEY_SLOTS = 15;
	localparam logic [7:0] FIELD_POLY = 8'h1b;
	localparam logic [63:0] ZERO = 64'h0;
	localparam logic [63:0] ONES = '1;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 160;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_t;

	typedef enum logic [1:0] {STEP_KEY, STEP_ENC, STEP_ROUNDS} step_t;

	typedef struct packed {
		step_t       op;
		logic [3:0]  arg;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        known;
		logic [63:0] want_hi;
		logic [63:0] want_lo;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = REQ_KEY_LOAD;
	logic [3:0]  key_slot = 4'd0;
	logic [63:0] block_hi = 64'h0;
	logic [63:0] block_lo = 64'h0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] cipher_hi;
	logic [63:0] cipher_lo;

	logic [7:0]  sbox_tab [256];
	logic [63:0] round_key_hi [KEY_SLOTS];
	logic [63:0] round_key_lo [KEY_SLOTS];
	logic [3:0]  rounds_set = RC_RESET;
	cipher_t     pending_ciphers [$];
	cipher_t     head;
	plan_row_t   plan [29];

	int errors = 0;
	int results_seen = 0;
	int n_loads = 0;
	int n_encrypts = 0;
	int n_settings = 0;
	int burst_left = 0;

	always #4 clk = ~clk;

	aes_block_encrypt #(.KEY_SLOTS(KEY_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.key_slot(key_slot),
		.block_hi(block_hi),
		.block_lo(block_lo),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cipher_hi(cipher_hi),
		.cipher_lo(cipher_lo)
	);

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return (x << 1) ^ ({8{x[7]}} & FIELD_POLY);
	endfunction

	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0])
				p = p ^ a;
			a = xtime(a);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic cipher_t aes_encrypt(input logic [127:0] pt);
		logic [7:0]   st [16];
		logic [7:0]   nx [16];
		logic [127:0] rk;
		logic [127:0] ct;
		logic [7:0]   a0, a1, a2, a3, t;
		int           last;
		last = rounds_set;
		if (last < 1)
			last = 1;
		if (last > KEY_SLOTS - 1)
			last = KEY_SLOTS - 1;
		rk = {round_key_hi[0], round_key_lo[0]};
		for (int i = 0; i < 16; i++)
			st[i] = pt[127-8*i -: 8] ^ rk[127-8*i -: 8];
		for (int r = 1; r <= last; r++) begin
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++)
					nx[4*c+w] = sbox_tab[st[4*((c+w)%4)+w]];
			for (int c = 0; c < 4; c++) begin
				a0 = nx[4*c];
				a1 = nx[4*c+1];
				a2 = nx[4*c+2];
				a3 = nx[4*c+3];
				if (r < last) begin
					t = a0 ^ a1 ^ a2 ^ a3;
					st[4*c]   = xtime(a0 ^ a1) ^ a0 ^ t;
					st[4*c+1] = xtime(a1 ^ a2) ^ a1 ^ t;
					st[4*c+2] = xtime(a2 ^ a3) ^ a2 ^ t;
					st[4*c+3] = xtime(a3 ^ a0) ^ a3 ^ t;
				end else begin
					st[4*c]   = a0;
					st[4*c+1] = a1;
					st[4*c+2] = a2;
					st[4*c+3] = a3;
				end
			end
			rk = {round_key_hi[r], round_key_lo[r]};
			for (int i = 0; i < 16; i++)
				st[i] = st[i] ^ rk[127-8*i -: 8];
		end
		for (int i = 0; i < 16; i++)
			ct[127-8*i -: 8] = st[i];
		return cipher_t'(ct);
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 15))
			0: return ZERO;
			1: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic offer(input logic kind, input logic [3:0] slot, input logic [63:0] hi,
			input logic [63:0] lo, input logic typed, input cipher_t typed_want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		key_slot <= slot;
		block_hi <= hi;
		block_lo <= lo;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (kind == REQ_KEY_LOAD) begin
			n_loads++;
			if (slot < KEY_SLOTS) begin
				round_key_hi[slot] = hi;
				round_key_lo[slot] = lo;
			end
		end else begin
			n_encrypts++;
			pending_ciphers.push_back(typed ? typed_want : aes_encrypt({hi, lo}));
		end
	endtask

	task automatic set_rounds(input logic [3:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_ciphers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		rounds_set = v;
		n_settings++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_ciphers.size() == 0) begin
				$display("%0t unexpected result: expected none, got %h %h",
					$time, cipher_hi, cipher_lo);
				errors++;
			end else begin
				head = pending_ciphers.pop_front();
				if (cipher_hi !== head.hi) begin
					$display("%0t cipher_hi mismatch: expected %h, got %h",
						$time, head.hi, cipher_hi);
					errors++;
				end
				if (cipher_lo !== head.lo) begin
					$display("%0t cipher_lo mismatch: expected %h, got %h",
						$time, head.lo, cipher_lo);
					errors++;
				end
			end
		end
	end

	initial begin
		int  mode;
		int  len;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(16, 96);
			repeat (len) begin
				@(negedge clk);
				if (!held && results_seen >= HOLD_AT_RESULT) begin
					held = 1'b1;
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	initial begin
		#5000000;
		$display("[aes_block_encrypt] ERROR");
		$finish;
	end

	initial begin
		logic [7:0]  p;
		logic [3:0]  rc;
		int          count;
		logic [3:0]  phase_rounds [6];
		for (int v = 0; v < 256; v++) begin
			p = 8'h01;
			repeat (254) p = gf_mult(p, 8'(v));
			sbox_tab[v] = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]}
				^ {p[3:0], p[7:4]} ^ 8'h63;
		end
		phase_rounds = '{4'd10, 4'd0, 4'd14, 4'd1, 4'd12, 4'd15};
		plan = '{
			'{STEP_KEY, 4'd0, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd1, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd2, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd3, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd4, 64'h8000000000000001, 64'h7ffffffffffffffe, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd5, 64'hdeadbeefcafef00d, 64'h0badc0de12345678, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd6, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd7, 64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd8, 64'h1122334455667788, 64'h99aabbccddeeff00, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd9, 64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd10, 64'h3c3c3c3c3c3c3c3c, 64'hc3c3c3c3c3c3c3c3, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd11, 64'h0000000100000002, 64'h0000000300000004, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd12, 64'h7a7a7a7a12121212, 64'h9e9e9e9e00000000, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd13, 64'hffffffff00000000, 64'h00000000ffffffff, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd14, ONES, ONES, 1'b0, ZERO, ZERO},
			'{STEP_KEY, 4'd15, ONES, ONES, 1'b0, ZERO, ZERO},
			'{STEP_ENC, 4'd0, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_ENC, 4'd15, ONES, ONES, 1'b0, ZERO, ZERO},
			'{STEP_ROUNDS, 4'd12, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_ENC, 4'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, ZERO, ZERO},
			'{STEP_ROUNDS, 4'd14, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_ENC, 4'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, ZERO, ZERO},
			'{STEP_ROUNDS, 4'd15, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_ENC, 4'd0, ONES, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_ROUNDS, 4'd0, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_ENC, 4'd0, ZERO, ZERO, 1'b1, 64'h6363636363636363, 64'h6363636363636363},
			'{STEP_ENC, 4'd0, ONES, ONES, 1'b1, 64'h1616161616161616, 64'h1616161616161616},
			'{STEP_ROUNDS, 4'd1, ZERO, ZERO, 1'b0, ZERO, ZERO},
			'{STEP_ENC, 4'd0, ZERO, ZERO, 1'b1, 64'h6363636363636363, 64'h6363636363636363}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(plan); i++) begin
			case (plan[i].op)
				STEP_ROUNDS: set_rounds(plan[i].arg);
				STEP_KEY: offer(REQ_KEY_LOAD, plan[i].arg, plan[i].hi, plan[i].lo, 1'b0, '0);
				default: offer(REQ_ENCRYPT, plan[i].arg, plan[i].hi, plan[i].lo, plan[i].known,
					{plan[i].want_hi, plan[i].want_lo});
			endcase
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			rc = (ph < 6) ? phase_rounds[ph] : 4'($urandom_range(0, 15));
			set_rounds(rc);
			count = PHASE_ITEMS;
			if ($urandom_range(0, 1) == 1) begin
				for (int s = 0; s < KEY_SLOTS; s++)
					offer(REQ_KEY_LOAD, 4'(s), rand_word(), rand_word(), 1'b0, '0);
				count -= KEY_SLOTS;
			end
			repeat (count) begin
				if ($urandom_range(0, 9) < 2)
					offer(REQ_KEY_LOAD, 4'($urandom_range(0, 15)), rand_word(), rand_word(),
						1'b0, '0);
				else
					offer(REQ_ENCRYPT, 4'($urandom_range(0, 15)), rand_word(), rand_word(),
						1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_ciphers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);

		$display("covered %0d key loads and %0d encryptions over %0d round-count settings,",
			n_loads, n_encrypts, n_settings);
		$display("with %0d ciphertexts checked under random gaps, stalls and one long hold-off",
			results_seen);
		if (errors == 0)
			$display("[aes_block_encrypt] OK");
		else
			$display("[aes_block_encrypt] ERROR");
		$finish;
	end

endmodule
